>>> sv/fdaow_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fdaow_pkg;

	// Largest image side handled, and the widths that follow from it.
	localparam int MAX_DIM = 8192;
	// A side length, 1 .. MAX_DIM.
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	// A position inside a side, 0 .. MAX_DIM-1.
	localparam int POS_W   = $clog2(MAX_DIM);
	// Product of two side lengths, up to MAX_DIM squared.
	localparam int PROD_W  = 2 * POS_W + 1;
	// Bit counter of the serial divider.
	localparam int CNT_W   = $clog2(PROD_W + 1);
	// Colour component width.
	localparam int COL_W   = 8;

	// Configuration register indexes.
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_WIDTH     = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_HEIGHT    = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic fit_mul;
		logic fit_div;
		logic fit_direct;
		logic fit_load;
		logic emit;
		logic step_mul;
		logic step_div;
		logic step_load;
		logic advance;
	} fdaow_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic frame_start;
		logic fit_needed;
		logic hit;
		logic out_busy;
		logic row_wrap;
		logic row_more;
		logic div_done;
	} fdaow_status_t;

endpackage

`default_nettype wire

>>> sv/fdaow_div.sv
`timescale 1ns / 1ps
`default_nettype none

module fdaow_div
	import fdaow_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [PROD_W-1:0] dividend,
	input  wire logic [DIM_W-1:0]  divisor,
	output logic      [PROD_W-1:0] quotient,
	output logic                   done
);

	logic [PROD_W-1:0] quo_q;
	logic [DIM_W-1:0]  rem_q;
	logic [DIM_W-1:0]  div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIM_W:0]    shifted;
	logic              fits;
	logic [DIM_W:0]    diff;

	// One restoring step: bring down the next dividend bit and try a subtract.
	always_comb begin
		shifted = {rem_q, quo_q[PROD_W-1]};
		fits    = shifted >= {1'b0, div_q};
		diff    = shifted - {1'b0, div_q};
	end

	// Sequencing of the bit steps, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[PROD_W-2:0], fits};
			rem_q <= fits ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

>>> sv/fdaow_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module fdaow_datapath
	import fdaow_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic [COL_W-1:0]     red_in,
	input  wire logic [COL_W-1:0]     green_in,
	input  wire logic [COL_W-1:0]     blue_in,
	input  wire logic [COL_W-1:0]     alpha_in,
	input  wire fdaow_cmd_t           cmd,
	output fdaow_status_t             status,
	input  wire logic                 out_stall,
	output logic                      out_valid,
	output logic      [COL_W-1:0]     red_out,
	output logic      [COL_W-1:0]     green_out,
	output logic      [COL_W-1:0]     blue_out,
	output logic      [DIM_W-1:0]     fitted_width,
	output logic      [DIM_W-1:0]     fitted_height,
	output logic                      frame_end
);

	// Saturate a register value into 1 .. MAX_DIM.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		return r;
	endfunction

	function automatic logic [PROD_W-1:0] mul_dim(input logic [DIM_W-1:0] a,
			input logic [DIM_W-1:0] b);
		logic [2*DIM_W-1:0] p;
		p = (2*DIM_W)'(a) * (2*DIM_W)'(b);
		return p[PROD_W-1:0];
	endfunction

	// Colour over white with rounding; the divide by 255 is an add-and-shift.
	function automatic logic [COL_W-1:0] blend(input logic [COL_W-1:0] c,
			input logic [COL_W-1:0] a);
		logic [2*COL_W-1:0] x;
		logic [2*COL_W:0]   y;
		x = (2*COL_W)'(c) * (2*COL_W)'(a)
			+ (2*COL_W)'(8'hFF) * (2*COL_W)'(8'hFF - a)
			+ (2*COL_W)'(8'h7F);
		y = (2*COL_W+1)'(x) + (2*COL_W+1)'(x >> COL_W) + (2*COL_W+1)'(1);
		return y[2*COL_W-1:COL_W];
	endfunction

	// Configuration registers.
	logic [DIM_W-1:0] src_w_q, src_h_q, max_w_q, max_h_q;
	// Frame state.
	logic [POS_W-1:0] col_q, row_q, want_col_q, want_row_q;
	logic [DIM_W-1:0] out_col_q, out_row_q, out_w_q, out_h_q;
	logic             fit_h_q;
	logic             step_row_q;
	// Held item and products.
	logic [COL_W-1:0]  red_q, green_q, blue_q, alpha_q;
	logic [PROD_W-1:0] prod_a_q, prod_b_q;
	// Output register.
	logic              out_valid_q;
	logic [COL_W-1:0]  red_out_q, green_out_q, blue_out_q;
	logic [DIM_W-1:0]  fw_q, fh_q;
	logic              frame_end_q;

	logic [DIM_W-1:0]  sw, sh, mw, mh;
	logic [DIM_W:0]    col_inc, row_inc, out_col_inc, out_row_inc;
	logic              div_start;
	logic [PROD_W-1:0] div_dividend;
	logic [DIM_W-1:0]  div_divisor;
	logic [PROD_W-1:0] div_quotient;
	logic              div_done;
	logic [DIM_W-1:0]  fit_q;

	// Clamped sizes and incremented counters.
	always_comb begin
		sw          = clamp_dim(src_w_q);
		sh          = clamp_dim(src_h_q);
		mw          = clamp_dim(max_w_q);
		mh          = clamp_dim(max_h_q);
		col_inc     = (DIM_W+1)'(col_q) + 1'b1;
		row_inc     = (DIM_W+1)'(row_q) + 1'b1;
		out_col_inc = {1'b0, out_col_q} + 1'b1;
		out_row_inc = {1'b0, out_row_q} + 1'b1;
		fit_q       = div_quotient[DIM_W-1:0];
	end

	// Status towards the controller.
	always_comb begin
		status.frame_start = (col_q == '0) && (row_q == '0);
		status.fit_needed  = (sw > mw) || (sh > mh);
		status.hit         = (out_row_q < out_h_q) && (out_col_q < out_w_q)
			&& (col_q == want_col_q) && (row_q == want_row_q);
		status.out_busy    = out_valid_q && out_stall;
		status.row_wrap    = out_col_inc >= {1'b0, out_w_q};
		status.row_more    = out_row_inc < {1'b0, out_h_q};
		status.div_done    = div_done;
	end

	// Divider operands: the fit side, or the next wanted source position.
	always_comb begin
		div_start = cmd.fit_div || cmd.step_div;
		if (cmd.fit_div) begin
			div_dividend = (prod_a_q > prod_b_q) ? prod_b_q : prod_a_q;
			div_divisor  = (prod_a_q > prod_b_q) ? sw : sh;
		end else begin
			div_dividend = prod_a_q;
			div_divisor  = step_row_q ? out_h_q : out_w_q;
		end
	end

	fdaow_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quotient),
		.done     (div_done)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= DIM_W'(1);
			src_h_q <= DIM_W'(1);
			max_w_q <= DIM_W'(MAX_DIM);
			max_h_q <= DIM_W'(MAX_DIM);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SOURCE_WIDTH:  src_w_q <= cfg_data;
				REG_SOURCE_HEIGHT: src_h_q <= cfg_data;
				REG_MAX_WIDTH:     max_w_q <= cfg_data;
				REG_MAX_HEIGHT:    max_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Source position, fitted size and output pixel counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			want_col_q <= '0;
			want_row_q <= '0;
			out_w_q    <= DIM_W'(1);
			out_h_q    <= DIM_W'(1);
			fit_h_q    <= 1'b0;
			step_row_q <= 1'b0;
		end else begin
			if (cmd.fit_mul) begin
				out_col_q  <= '0;
				out_row_q  <= '0;
				want_col_q <= '0;
				want_row_q <= '0;
			end
			if (cmd.fit_div)
				fit_h_q <= prod_a_q > prod_b_q;
			if (cmd.fit_direct) begin
				out_w_q <= sw;
				out_h_q <= sh;
			end
			if (cmd.fit_load) begin
				if (fit_h_q) begin
					out_w_q <= mw;
					out_h_q <= (fit_q == '0) ? DIM_W'(1) : fit_q;
				end else begin
					out_w_q <= (fit_q == '0) ? DIM_W'(1) : fit_q;
					out_h_q <= mh;
				end
			end
			if (cmd.emit) begin
				step_row_q <= status.row_wrap;
				if (status.row_wrap) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_inc[DIM_W-1:0];
					want_col_q <= '0;
				end else begin
					out_col_q <= out_col_inc[DIM_W-1:0];
				end
			end
			if (cmd.step_load) begin
				if (step_row_q)
					want_row_q <= div_quotient[POS_W-1:0];
				else
					want_col_q <= div_quotient[POS_W-1:0];
			end
			if (cmd.advance) begin
				if (col_inc >= (DIM_W+1)'(sw)) begin
					col_q <= '0;
					row_q <= (row_inc >= (DIM_W+1)'(sh)) ? '0 : row_inc[POS_W-1:0];
				end else begin
					col_q <= col_inc[POS_W-1:0];
				end
			end
		end
	end

	// Held item and products for the divider.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			red_q   <= red_in;
			green_q <= green_in;
			blue_q  <= blue_in;
			alpha_q <= alpha_in;
		end
		if (cmd.fit_mul) begin
			prod_a_q <= mul_dim(sw, mh);
			prod_b_q <= mul_dim(sh, mw);
		end else if (cmd.step_mul) begin
			prod_a_q <= step_row_q ? mul_dim(out_row_q, sh) : mul_dim(out_col_q, sw);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			red_out_q   <= blend(red_q, alpha_q);
			green_out_q <= blend(green_q, alpha_q);
			blue_out_q  <= blend(blue_q, alpha_q);
			fw_q        <= out_w_q;
			fh_q        <= out_h_q;
			frame_end_q <= (out_row_inc == {1'b0, out_h_q})
				&& (out_col_inc == {1'b0, out_w_q});
		end
	end

	assign out_valid     = out_valid_q;
	assign red_out       = red_out_q;
	assign green_out     = green_out_q;
	assign blue_out      = blue_out_q;
	assign fitted_width  = fw_q;
	assign fitted_height = fh_q;
	assign frame_end     = frame_end_q;

endmodule

`default_nettype wire

>>> sv/fdaow_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fdaow_ctrl
	import fdaow_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire fdaow_status_t status,
	output fdaow_cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIT_MUL,
		S_FIT_SEL,
		S_FIT_WAIT,
		S_CHECK,
		S_STEP_MUL,
		S_STEP_DIV,
		S_STEP_WAIT
	} state_t;

	state_t state_q, state_d;

	// Next state and commands for the datapath.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.frame_start ? S_FIT_MUL : S_CHECK;
				end
			end
			S_FIT_MUL: begin
				cmd.fit_mul = 1'b1;
				state_d     = S_FIT_SEL;
			end
			S_FIT_SEL: begin
				if (status.fit_needed) begin
					cmd.fit_div = 1'b1;
					state_d     = S_FIT_WAIT;
				end else begin
					cmd.fit_direct = 1'b1;
					state_d        = S_CHECK;
				end
			end
			S_FIT_WAIT: begin
				if (status.div_done) begin
					cmd.fit_load = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!status.hit) begin
					cmd.advance = 1'b1;
					state_d     = S_IDLE;
				end else if (!status.out_busy) begin
					cmd.emit = 1'b1;
					if (status.row_wrap && !status.row_more) begin
						cmd.advance = 1'b1;
						state_d     = S_IDLE;
					end else begin
						state_d = S_STEP_MUL;
					end
				end
			end
			S_STEP_MUL: begin
				cmd.step_mul = 1'b1;
				state_d      = S_STEP_DIV;
			end
			S_STEP_DIV: begin
				cmd.step_div = 1'b1;
				state_d      = S_STEP_WAIT;
			end
			S_STEP_WAIT: begin
				if (status.div_done) begin
					cmd.step_load = 1'b1;
					cmd.advance   = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

`default_nettype wire

>>> sv/fit_downscale_alpha_over_white.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                Payload
// in       in_valid / in_stall      red_in, green_in, blue_in, alpha_in
// out      out_valid / out_stall    red_out, green_out, blue_out, fitted_width,
//                                   fitted_height, frame_end
// cfg      cfg_write                cfg_index, cfg_data
//
// An item that yields no pixel, or the last pixel of a frame, needs no division; any
// other pixel waits for the bit-serial divider (one bit a cycle over the
// 27-bit product) to work out the next wanted source position.
// The first item of a frame also goes through the fit, which uses the divider to scale a side.
// Reset is asynchronous and active low; it restores the register defaults.
// A stalled output holds its item; the next item is taken but waits if it yields a pixel.

module fit_downscale_alpha_over_white
	import fdaow_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [COL_W-1:0]     red_in,
	input  wire logic [COL_W-1:0]     green_in,
	input  wire logic [COL_W-1:0]     blue_in,
	input  wire logic [COL_W-1:0]     alpha_in,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [COL_W-1:0]     red_out,
	output logic      [COL_W-1:0]     green_out,
	output logic      [COL_W-1:0]     blue_out,
	output logic      [DIM_W-1:0]     fitted_width,
	output logic      [DIM_W-1:0]     fitted_height,
	output logic                      frame_end
);

	fdaow_cmd_t    cmd;
	fdaow_status_t status;

	// Sequencer for the fit, pixel selection and position update.
	fdaow_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Counters, divider, blending and output register.
	fdaow_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.red_in        (red_in),
		.green_in      (green_in),
		.blue_in       (blue_in),
		.alpha_in      (alpha_in),
		.cmd           (cmd),
		.status        (status),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.red_out       (red_out),
		.green_out     (green_out),
		.blue_out      (blue_out),
		.fitted_width  (fitted_width),
		.fitted_height (fitted_height),
		.frame_end     (frame_end)
	);

endmodule

`default_nettype wire
